[design/i2da_pkg.sv]
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types, character codes and the decimal step function for the
// 32-bit binary to decimal ASCII formatter.
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int DigitCount = 10;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // Index of the decimal place being printed: 0 for units, 9 for 10^9.
   typedef logic [3:0] place_type;

   // One registered number waiting to be printed.
   typedef struct packed {
      logic       valid;
      logic       neg;
      logic [31:0] mag;
      place_type  top_place;
   } item_type;

   // multiple * 10^power, wide enough for 9 * 10^9.
   function automatic logic [35:0] digit_step(input int unsigned power,
                                              input int unsigned multiple);
      logic [35:0] acc;
      acc = 36'(multiple);
      for (int unsigned i = 0; i < power; i++) begin
         acc = acc * 36'd10;
      end
      return acc;
   endfunction

endpackage

[design/int32_to_decimal_ascii_core.sv]
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_core
// Streams a 32-bit number out as decimal ASCII characters, one per word.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one number per word: the 32-bit value in tdata,
//   the unsigned-mode and zero-pad flags in tuser. The rsp channel returns
//   the characters of that number one word each, most significant first, a
//   leading '-' for a negative signed value, tlast on the final character.
//   Zero always prints as a lone '0'; with zero-pad set any other value
//   prints as exactly ten digits after its sign.
// Path: from idle, an accepted number passes the input register, the
//   sequencer state register and the output register to its first character.
// Throughput: a number prints as 1 to 11 characters, one per word; the
//   digit sequencer produces one digit per cycle, so the rsp channel sets
//   the rate. The next number is taken into the input register while the
//   current one is still printing, and its first character follows the
//   previous tlast with no gap.
// Reset clears the input, busy and output valid flags; nothing else is needed.
// When the receiver holds tready low the output word is held and the
// sequencer stalls; once the input register is full, req_tready drops.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [0] unsigned_mode, [1] zero_pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] character
   output logic        rsp_tlast
);
   import i2da_pkg::*;

   // number waiting in the input register, and its hand-over strobe
   item_type item;
   logic     take;

   // Register the number, split sign from magnitude, find its top place.
   i2da_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (item),
      .take       (take)
   );

   // Print sign then digits via output register, one word per unstalled cycle.
   i2da_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[design/i2da_front.sv]
// ----------------------------------------------------------------------------
// i2da_front
// Input register: takes a number, splits sign and magnitude and finds the
// decimal place of the first character to print.
// ----------------------------------------------------------------------------
module i2da_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,
   input  logic [1:0]        req_tuser,
   output i2da_pkg::item_type item,
   input  logic              take
);
   import i2da_pkg::*;

   item_type    item_ff;
   item_type    item_in;
   logic        neg;
   logic [31:0] mag;
   place_type   len_place;

   assign req_tready = !item_ff.valid || take;
   assign item       = item_ff;

   always_comb begin
      neg = !req_tuser[0] && req_tdata[31];
      mag = neg ? (32'd0 - req_tdata) : req_tdata;
      // highest place whose power of ten fits in the magnitude
      len_place = '0;
      for (int k = 1; k < DigitCount; k++) begin
         if ({4'b0, mag} >= digit_step(k, 1)) begin
            len_place = place_type'(k);
         end
      end
   end

   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.valid = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         item_in.valid     = 1'b1;
         item_in.neg       = neg;
         item_in.mag       = mag;
         // zero prints a lone '0' even when padded
         item_in.top_place = (req_tuser[1] && (mag != 32'd0)) ?
                             place_type'(DigitCount - 1) : len_place;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.neg       <= item_in.neg;
      item_ff.mag       <= item_in.mag;
      item_ff.top_place <= item_in.top_place;
   end

endmodule

[design/i2da_digit.sv]
// ----------------------------------------------------------------------------
// i2da_digit
// One decimal digit per call: compare the remainder against the nine
// multiples of the selected power of ten and subtract the largest that fits.
// ----------------------------------------------------------------------------
module i2da_digit (
   input  logic [31:0] rem,
   input  logic [3:0]  place,
   output logic [3:0]  digit,
   output logic [31:0] rem_next
);
   import i2da_pkg::*;

   logic [35:0] step_sel [1:9];
   logic [35:0] sub;

   for (genvar c = 1; c < 10; c++) begin : g_mult
      always_comb begin
         step_sel[c] = '0;
         for (int k = 0; k < DigitCount; k++) begin
            if (place == 4'(k)) begin
               step_sel[c] = digit_step(k, c);
            end
         end
      end
   end

   always_comb begin
      digit = '0;
      sub   = '0;
      for (int c = 1; c < 10; c++) begin
         if ({4'b0, rem} >= step_sel[c]) begin
            digit = 4'(c);
            sub   = step_sel[c];
         end
      end
      rem_next = rem - sub[31:0];
   end

endmodule

[design/i2da_serial.sv]
// ----------------------------------------------------------------------------
// i2da_serial
// Character sequencer and output register: prints the sign, then one digit
// per cycle while not stalled, from the top place down to units.
// ----------------------------------------------------------------------------
module i2da_serial (
   input  logic               clock,
   input  logic               reset,
   input  i2da_pkg::item_type item,
   output logic               take,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);
   import i2da_pkg::*;

   logic        busy_ff, busy_in;
   logic        minus_ff, minus_in;
   logic [31:0] rem_ff, rem_in;
   place_type   place_ff, place_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_last_ff, out_last_in;

   logic        out_free;
   logic        emit;
   logic        emit_last;
   logic [3:0]  digit;
   logic [31:0] rem_next;

   i2da_digit u_digit (
      .rem      (rem_ff),
      .place    (place_ff),
      .digit    (digit),
      .rem_next (rem_next)
   );

   assign out_free  = !out_valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   assign emit_last = emit && !minus_ff && (place_ff == '0);
   assign take      = item.valid && (!busy_ff || emit_last);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      busy_in      = busy_ff;
      minus_in     = minus_ff;
      rem_in       = rem_ff;
      place_in     = place_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (emit) begin
         out_valid_in = 1'b1;
         out_last_in  = !minus_ff && (place_ff == '0);
         if (minus_ff) begin
            out_char_in = ASCII_MINUS;
            minus_in    = 1'b0;
         end else begin
            out_char_in = ASCII_ZERO + {4'b0, digit};
            rem_in      = rem_next;
            if (place_ff != '0) begin
               place_in = place_ff - 4'd1;
            end
         end
         if (emit_last) begin
            busy_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end

      if (take) begin
         busy_in  = 1'b1;
         minus_in = item.neg;
         rem_in   = item.mag;
         place_in = item.top_place;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      minus_ff    <= minus_in;
      rem_ff      <= rem_in;
      place_ff    <= place_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

[sim/tb_int32_to_decimal_ascii_core.sv]
// ----------------------------------------------------------------------------
// tb_int32_to_decimal_ascii_core
// Self-checking bench for the 32-bit decimal ASCII formatter. Numbers go in
// on the req stream and a predictor works out the characters that each one
// must give. The rsp words are compared in order against those characters.
// A directed set covers the edge values and every flag combination. A
// random set follows. Both sides add idle gaps throughout, and the receiver
// holds off once, long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb_int32_to_decimal_ascii_core;

   timeunit 1ns;
   timeprecision 1ps;

   import i2da_pkg::*;

   localparam int RandomNumbers = 248;
   localparam int CycleLimit    = 500000;
   localparam int LongHoldOff   = 400;   // receiver hold-off, in cycles
   localparam int DrainCycles   = 20;

   // Holds the characters still owed by the block and checks each rsp word
   // against the oldest of them.
   class decimal_scoreboard;
      typedef struct packed {
         logic [7:0] ch;
         logic       last;
      } char_word_type;

      char_word_type owed_chars[$];
      int            mismatches = 0;

      // Work out the decimal text of one accepted number and queue it.
      function void note_number(logic [31:0] value, logic unsigned_mode,
                                logic zero_pad);
         logic [31:0] mag;
         logic [31:0] divisor;
         logic [3:0]  digit;
         bit          seen;
         int          n;
         if (value == 32'd0) begin
            owed_chars.push_back('{ch: ASCII_ZERO, last: 1'b1});
            return;
         end
         mag = value;
         if (!unsigned_mode && value[31]) begin
            owed_chars.push_back('{ch: ASCII_MINUS, last: 1'b0});
            mag = 32'd0 - value;
         end
         divisor = 32'd1_000_000_000;
         seen    = 1'b0;
         for (int p = 0; p < DigitCount; p++) begin
            digit = 4'(mag / divisor);
            mag   = mag % divisor;
            if (digit != 4'd0) begin
               seen = 1'b1;
            end
            if (seen || zero_pad) begin
               owed_chars.push_back('{ch: ASCII_ZERO + 8'(digit), last: 1'b0});
            end
            divisor = divisor / 32'd10;
         end
         n = owed_chars.size();
         owed_chars[n-1].last = 1'b1;
      endfunction

      function void check_char(logic [7:0] ch, logic last);
         char_word_type want;
         if (owed_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: unexpected word %02h last %0b", $realtime, ch, last);
            end
            return;
         end
         want = owed_chars.pop_front();
         if (want.ch !== ch || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: expected %02h last %0b, got %02h last %0b",
                        $realtime, want.ch, want.last, ch, last);
            end
         end
      endfunction

      function int pending();
         return owed_chars.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = 32'd0;   // [31:0] value
   logic [1:0]  req_tuser  = 2'd0;    // [0] unsigned_mode, [1] zero_pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;            // [7:0] character
   logic        rsp_tlast;

   decimal_scoreboard text_board = new;
   int                cycle_count = 0;
   int                sender_run  = 0;   // words left in a no-gap stretch
   int                reader_run  = 0;

   int32_to_decimal_ascii_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Pick a random wait before the next word. Now and then start a stretch
   // of back-to-back words so that some phases see no idling at all.
   function automatic int next_wait(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // Offer one number and hold it until the block takes it. Keep tvalid high
   // across back-to-back words rather than dropping and raising it in one step.
   task automatic send_number(logic [31:0] value, logic unsigned_mode,
                              logic zero_pad);
      int gap;
      gap = next_wait(sender_run);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {zero_pad, unsigned_mode};
      do @(posedge clock); while (!req_tready);
      text_board.note_number(value, unsigned_mode, zero_pad);
   endtask

   // Random number with a bias towards short texts, powers of ten and values
   // around the sign boundary; full-width values keep every bit toggling.
   function automatic logic [31:0] pick_value();
      logic [31:0] pow10;
      pow10 = 32'd1;
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 99);
         2: return $urandom_range(0, 99999);
         3: begin
            repeat ($urandom_range(0, 9)) pow10 = pow10 * 32'd10;
            return pow10 + $urandom_range(0, 2) - 32'd1;
         end
         4: return 32'd0 - $urandom_range(1, 1000);
         default: return 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
      endcase
   endfunction

   // Receiver: stall by next_wait before each word, once hold off for a
   // long stretch so that the block backs up into req_tready.
   initial begin
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         stall = next_wait(reader_run);
         if (taken == 60) begin
            stall = LongHoldOff;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // Check every accepted rsp word against the oldest owed character.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         text_board.check_char(rsp_tdata, rsp_tlast);
      end
   end

   // Watchdog: drop the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("int32_to_decimal_ascii_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero with every flag combination: always a lone '0'.
      send_number(32'd0, 1'b0, 1'b0);
      send_number(32'd0, 1'b0, 1'b1);
      send_number(32'd0, 1'b1, 1'b0);
      send_number(32'd0, 1'b1, 1'b1);
      // Single and short digit runs, padded and not.
      send_number(32'd1, 1'b0, 1'b0);
      send_number(32'd9, 1'b1, 1'b1);
      send_number(32'd10, 1'b0, 1'b1);
      send_number(32'd100, 1'b1, 1'b0);
      send_number(32'd999_999_999, 1'b0, 1'b0);
      send_number(32'd1_000_000_000, 1'b1, 1'b0);
      // All ones: -1 signed, the largest value unsigned.
      send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b0, 1'b1);   // eleven characters
      send_number(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b1, 1'b1);
      // Most negative value and its neighbours across the sign boundary.
      send_number(32'h8000_0000, 1'b0, 1'b0);
      send_number(32'h8000_0000, 1'b0, 1'b1);
      send_number(32'h8000_0000, 1'b1, 1'b0);
      send_number(32'h7FFF_FFFF, 1'b0, 1'b0);
      send_number(32'h7FFF_FFFF, 1'b0, 1'b1);
      send_number(32'h8000_0001, 1'b0, 1'b0);
      send_number(32'hAAAA_AAAA, 1'b1, 1'b1);
      send_number(32'h5555_5555, 1'b1, 1'b0);

      for (int i = 0; i < RandomNumbers; i++) begin
         send_number(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      req_tvalid <= 1'b0;

      // Drain what is still owed, then leave room for any stray word.
      while (text_board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (text_board.mismatches == 0 && text_board.pending() == 0) begin
         $display("int32_to_decimal_ascii_core regression: pass");
      end else begin
         $display("int32_to_decimal_ascii_core regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
design/i2da_pkg.sv
design/i2da_front.sv
design/i2da_digit.sv
design/i2da_serial.sv
design/int32_to_decimal_ascii_core.sv
sim/tb_int32_to_decimal_ascii_core.sv
